// ----- hdl/ibd_pkg.sv -----
// Shared types and constants for the image box downscaler.
// Used by every module of image_box_downscale; depends on nothing.
package ibd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int SIZE_W = 12;                    // frame size register width
    localparam int POS_W  = $clog2(MAX_WIDTH);     // column / row position
    localparam int PIX_W  = 16;
    localparam int SUM_W  = 20;
    localparam int CNT_W  = 5;
    localparam int ACC_W  = SUM_W + CNT_W;

    localparam int ACC_COLS = MAX_WIDTH / 2;
    localparam int IDX_W    = $clog2(ACC_COLS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = SUM_W / DIV_BITS_PER_STAGE;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [SIZE_W-1:0] QVGA_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] QVGA_HEIGHT = SIZE_W'(480);

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_DEPTH_MODE   = 3'd2,
        REG_QVGA_ENABLE  = 3'd3,
        REG_QUARTER_RES  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        QRM_OFF     = 2'd0,
        QRM_HALF    = 2'd1,
        QRM_QUARTER = 2'd2
    } qrm_t;

    typedef enum logic [1:0] {
        FACT_1 = 2'd0,
        FACT_2 = 2'd1,
        FACT_4 = 2'd2
    } factor_t;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic              depth_mode;
        logic              qvga_enable;
        logic [1:0]        quarter_res_mode;
    } cfg_t;

    // One finished block (or passed-through pixel) waiting for the divide
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } job_t;

endpackage

// ----- hdl/image_box_downscale.sv -----
// Top level of the streaming 2x2 / 4x4 box-filter image downscaler.
// Depends on ibd_pkg, ibd_regs, ibd_front, ibd_fifo and ibd_back.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  s_tdata[15:0] pixel_in
//   m_*       out   m_tvalid/m_tready  m_tdata[15:0] pixel_out, m_tlast frame_end
//   apb       in    psel/penable       paddr, pwdata, prdata; pready tied high
//
// Sustained rate is one pixel per cycle while s_tready is high; m_tvalid rises after the
// pixel completing a result passes the queue, 5 divide stages and the output register.
// The 4-entry job queue decouples the accumulator memory port from the divider.
// A result held by m_tready low freezes the divider pipeline; s_tready drops once
// the queue plus the job in the read-modify-write stage reach 4 entries.
// Reset restores 640x480 pass-through; accumulator memory is not cleared.
module image_box_downscale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ibd_pkg::PIX_W-1:0] s_tdata,     // [15:0] pixel_in
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ibd_pkg::PIX_W-1:0] m_tdata,     // [15:0] pixel_out
    output logic                      m_tlast,     // frame_end
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ibd_pkg::ADDR_W-1:0] paddr,
    input  logic [ibd_pkg::DATA_W-1:0] pwdata,
    output logic [ibd_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);
    import ibd_pkg::*;

    cfg_t              cfg;
    logic              push, pop, head_valid;
    job_t              push_job, head_job;
    logic [QCNT_W-1:0] queue_count;

    ibd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ibd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .queue_count (queue_count),
        .push        (push),
        .push_job    (push_job)
    );

    ibd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (queue_count)
    );

    ibd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (head_valid),
        .q_job    (head_job),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/ibd_regs.sv -----
// APB-style configuration registers of the box downscaler.
// Depends on ibd_pkg.
module ibd_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ibd_pkg::ADDR_W-1:0] paddr,
    input  logic [ibd_pkg::DATA_W-1:0] pwdata,
    output logic [ibd_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output ibd_pkg::cfg_t             cfg
);
    import ibd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width      <= QVGA_WIDTH;
            cfg_reg.frame_height     <= QVGA_HEIGHT;
            cfg_reg.depth_mode       <= 1'b0;
            cfg_reg.qvga_enable      <= 1'b0;
            cfg_reg.quarter_res_mode <= QRM_OFF;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_WIDTH:  cfg_reg.frame_width      <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height     <= pwdata[SIZE_W-1:0];
                REG_DEPTH_MODE:   cfg_reg.depth_mode       <= pwdata[0];
                REG_QVGA_ENABLE:  cfg_reg.qvga_enable      <= pwdata[0];
                REG_QUARTER_RES:  cfg_reg.quarter_res_mode <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_FRAME_WIDTH:  prdata[SIZE_W-1:0] = cfg_reg.frame_width;
            REG_FRAME_HEIGHT: prdata[SIZE_W-1:0] = cfg_reg.frame_height;
            REG_DEPTH_MODE:   prdata[0]          = cfg_reg.depth_mode;
            REG_QVGA_ENABLE:  prdata[0]          = cfg_reg.qvga_enable;
            REG_QUARTER_RES:  prdata[1:0]        = cfg_reg.quarter_res_mode;
            default:          prdata             = '0;
        endcase
    end

endmodule

// ----- hdl/ibd_front.sv -----
// Front end: pixel position tracking, factor decision, row sums and the
// column accumulator memory. Emits finished blocks as jobs. Depends on ibd_pkg.
module ibd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ibd_pkg::cfg_t             cfg,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ibd_pkg::PIX_W-1:0] s_tdata,     // [15:0] pixel_in
    input  logic [ibd_pkg::QCNT_W-1:0] queue_count,
    output logic                      push,
    output ibd_pkg::job_t             push_job
);
    import ibd_pkg::*;

    // column accumulators: {count, sum} per block column
    logic [ACC_W-1:0] acc_mem [ACC_COLS];

    logic [POS_W-1:0]  col_reg, row_reg, col_next, row_next;
    logic [SUM_W-1:0]  row_sum_reg, row_sum_next;
    logic [CNT_W-1:0]  row_cnt_reg, row_cnt_next;

    // second stage: accumulator read-modify-write
    logic              b_valid_reg;
    logic              b_acc_reg, b_emit_reg, b_first_reg, b_last_reg;
    logic [SUM_W-1:0]  b_sum_reg;
    logic [CNT_W-1:0]  b_cnt_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic [ACC_W-1:0]  rd_reg;

    logic [SIZE_W-1:0] w_eff, h_eff;
    factor_t           factor;
    logic [POS_W-1:0]  col, row;
    logic [1:0]        mask, jx, iy;
    logic [PIX_W-1:0]  v;
    logic              nz, last, is_pass, blk_end, accept, wrap;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] col_inc, row_inc;
    logic [SUM_W-1:0]  acc_sum;
    logic [CNT_W-1:0]  acc_cnt;

    assign s_tready = (QCNT_W'(queue_count) + QCNT_W'(b_valid_reg)) < QCNT_W'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (cfg.frame_width == '0)
            w_eff = SIZE_W'(1);
        else if (cfg.frame_width > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = cfg.frame_width;

        if (cfg.frame_height == '0)
            h_eff = SIZE_W'(1);
        else if (cfg.frame_height > SIZE_W'(MAX_HEIGHT))
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = cfg.frame_height;

        if ((cfg.qvga_enable && w_eff == QVGA_WIDTH && h_eff == QVGA_HEIGHT) ||
            (cfg.quarter_res_mode == QRM_HALF && !w_eff[0] && !h_eff[0]))
            factor = FACT_2;
        else if (cfg.quarter_res_mode == QRM_QUARTER && w_eff[1:0] == 2'b00 &&
                 h_eff[1:0] == 2'b00)
            factor = FACT_4;
        else
            factor = FACT_1;

        unique case (factor)
            FACT_2:  mask = 2'b01;
            FACT_4:  mask = 2'b11;
            default: mask = 2'b00;
        endcase

        // a position left out of range by a size change restarts at zero
        col = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        row = ({1'b0, row_reg} >= h_eff) ? '0 : row_reg;
        jx  = col[1:0] & mask;
        iy  = row[1:0] & mask;
        last = ({1'b0, col} == w_eff - SIZE_W'(1)) && ({1'b0, row} == h_eff - SIZE_W'(1));

        v  = cfg.depth_mode ? s_tdata : {8'h00, s_tdata[7:0]};
        nz = cfg.depth_mode ? (s_tdata != '0) : 1'b1;

        is_pass = (factor == FACT_1);
        blk_end = !is_pass && (jx == mask);
        idx     = (factor == FACT_4) ? IDX_W'(col >> 2) : IDX_W'(col >> 1);

        if (jx == 2'b00)
        begin
            row_sum_next = SUM_W'(v);
            row_cnt_next = CNT_W'(nz);
        end
        else
        begin
            row_sum_next = row_sum_reg + SUM_W'(v);
            row_cnt_next = row_cnt_reg + CNT_W'(nz);
        end

        col_inc = {1'b0, col} + SIZE_W'(1);
        row_inc = {1'b0, row} + SIZE_W'(1);
        wrap    = (col_inc >= w_eff);
        col_next = wrap ? '0 : col_inc[POS_W-1:0];
        if (!wrap)
            row_next = row;
        else if (row_inc >= h_eff)
            row_next = '0;
        else
            row_next = row_inc[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            row_sum_reg <= '0;
            row_cnt_reg <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept && (is_pass || blk_end);
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (!is_pass)
                begin
                    row_sum_reg <= row_sum_next;
                    row_cnt_reg <= row_cnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_acc_reg   <= blk_end;
            b_emit_reg  <= is_pass || (blk_end && iy == mask);
            b_first_reg <= is_pass || (iy == 2'b00);
            b_last_reg  <= last;
            b_sum_reg   <= is_pass ? SUM_W'(v) : row_sum_next;
            b_cnt_reg   <= is_pass ? CNT_W'(1) : row_cnt_next;
            b_idx_reg   <= idx;
            rd_reg      <= acc_mem[idx];
        end
    end

    // top block row starts a fresh column sum, later rows add to it
    assign acc_sum = b_first_reg ? b_sum_reg : rd_reg[SUM_W-1:0] + b_sum_reg;
    assign acc_cnt = b_first_reg ? b_cnt_reg : rd_reg[ACC_W-1:SUM_W] + b_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && b_acc_reg)
            acc_mem[b_idx_reg] <= {acc_cnt, acc_sum};
    end

    assign push          = b_valid_reg && b_emit_reg;
    assign push_job.sum  = acc_sum;
    assign push_job.cnt  = acc_cnt;
    assign push_job.last = b_last_reg;

endmodule

// ----- hdl/ibd_fifo.sv -----
// Short job queue between the front end and the divide back end.
// Depends on ibd_pkg.
module ibd_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ibd_pkg::job_t              push_job,
    input  logic                       pop,
    output logic                       head_valid,
    output ibd_pkg::job_t              head_job,
    output logic [ibd_pkg::QCNT_W-1:0] count
);
    import ibd_pkg::*;

    job_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_pop;

    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- hdl/ibd_back.sv -----
// Back end: pipelined restoring divider (sum / count) and output register.
// Depends on ibd_pkg.
module ibd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  ibd_pkg::job_t             q_job,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ibd_pkg::PIX_W-1:0] m_tdata,     // [15:0] pixel_out
    output logic                      m_tlast      // frame_end
);
    import ibd_pkg::*;

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [SUM_W-1:0] qd;    // dividend bits shift out, quotient bits shift in
    } div_acc_t;

    function automatic div_acc_t div_step(input div_acc_t a, input logic [CNT_W-1:0] d);
        div_acc_t     r;
        logic [CNT_W:0] t;
        r = a;
        for (int k = 0; k < DIV_BITS_PER_STAGE; k++)
        begin
            t    = {r.rem, r.qd[SUM_W-1]};
            r.qd = {r.qd[SUM_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t       = t - {1'b0, d};
                r.qd[0] = 1'b1;
            end
            r.rem = t[CNT_W-1:0];
        end
        return r;
    endfunction

    logic             st_valid_reg [DIV_STAGES];
    div_acc_t         st_acc_reg   [DIV_STAGES];
    logic [CNT_W-1:0] st_div_reg   [DIV_STAGES];
    logic             st_last_reg  [DIV_STAGES];

    logic             out_valid_reg, out_last_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic             adv;
    div_acc_t         first_in;

    // whole pipeline moves together unless the output holds an untaken result
    assign adv      = !out_valid_reg || m_tready;
    assign q_pop    = adv && q_valid;
    assign first_in = '{rem: '0, qd: q_job.sum};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                st_valid_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_valid_reg[0] <= q_valid;
            for (int i = 1; i < DIV_STAGES; i++)
                st_valid_reg[i] <= st_valid_reg[i-1];
            out_valid_reg <= st_valid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_acc_reg[0]  <= div_step(first_in, q_job.cnt);
            st_div_reg[0]  <= q_job.cnt;
            st_last_reg[0] <= q_job.last;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                st_acc_reg[i]  <= div_step(st_acc_reg[i-1], st_div_reg[i-1]);
                st_div_reg[i]  <= st_div_reg[i-1];
                st_last_reg[i] <= st_last_reg[i-1];
            end
            // all-zero depth block has no samples: mean is zero
            out_data_reg <= (st_div_reg[DIV_STAGES-1] == '0) ? '0 :
                            st_acc_reg[DIV_STAGES-1].qd[PIX_W-1:0];
            out_last_reg <= st_last_reg[DIV_STAGES-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/ibd_checker.sv -----
// Port-level checks for image_box_downscale, attached by bind.
// Depends on ibd_pkg.
module ibd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ibd_pkg::PIX_W-1:0]  m_tdata,
    input logic                       m_tlast,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic                       pready,
    input logic [ibd_pkg::ADDR_W-1:0] paddr,
    input logic [ibd_pkg::DATA_W-1:0] pwdata,
    input logic [ibd_pkg::DATA_W-1:0] prdata
);
    import ibd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped without a transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // width register reads back what was written
    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready &&
         paddr[ADDR_W-1:2] == REG_FRAME_WIDTH)
        ##1 (paddr[ADDR_W-1:2] == REG_FRAME_WIDTH)
        |-> prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))
        else $error("frame_width readback mismatch");

    // one-bit mode registers keep their unused bits clear
    a_mode_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (paddr[ADDR_W-1:2] == REG_DEPTH_MODE || paddr[ADDR_W-1:2] == REG_QVGA_ENABLE)
        |-> prdata[DATA_W-1:1] == '0)
        else $error("mode register reads back stray bits");

endmodule

bind image_box_downscale ibd_checker u_ibd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
